FILE: rtl/dtfp_pkg.sv
`timescale 1ns / 1ps
// Shared codes, character constants and the end-of-number record for the decimal parser.
package dtfp_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 64;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_EMPTY     = 3'd1;
  localparam status_t ST_BAD_INT   = 3'd2;
  localparam status_t ST_BAD_FRAC  = 3'd3;
  localparam status_t ST_TOO_MANY  = 3'd4;
  localparam status_t ST_NO_DIGITS = 3'd5;
  localparam status_t ST_OVERFLOW  = 3'd6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Everything but the integer part that the final stage needs.
  typedef struct packed {
    logic       neg;
    logic [6:0] frac_accum;
    logic [1:0] frac_count;
    status_t    status;
  } fin_t;

  // Fraction scaled to two digits (at most 99).
  function automatic logic [6:0] frac_scaled(input logic [6:0] acc, input logic [1:0] cnt);
    logic [6:0] res;
    begin
      case (cnt)
        2'd0:    res = 7'd0;
        2'd1:    res = 7'({acc, 3'b000} + {2'b00, acc, 1'b0});
        default: res = acc;
      endcase
      return res;
    end
  endfunction

endpackage

FILE: rtl/decimal_text_to_fixed_point.sv
`timescale 1ns / 1ps
// Top level: decimal text parser with a finish stage and a result register.
//
// Streams one ASCII character per transfer; is_last marks the final character
// of a number. An optional '+' or '-', integer digits, an optional '.' and up
// to two fraction digits are accepted. For each final character one result
// transfer follows, carrying the value in hundredths (signed, VALUE_WIDTH bits,
// negated for a minus sign) and a status code (ok, empty, bad integer digit,
// bad fraction digit, too many fraction digits, no digits, overflow); the
// value is zero whenever the status is not ok. The first error of a number is
// kept and later characters of that number are ignored. Throughput is one
// character per cycle while in_ready is high. A result is offered once its
// final character has passed the finish stage and the result register: the
// character update (multiply by ten, add, saturate) runs in the cycle of the
// input transfer and lands in the finish stage, and from there, once the
// result register is empty or draining, the integer part is scaled by 100,
// the fraction is added and the signed range is checked into the result
// register. in_ready drops only while both the finish stage and the result
// register are full and the result is not being drained.
module decimal_text_to_fixed_point #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_code,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] hundredths,
  output dtfp_pkg::status_t             status
);
  import dtfp_pkg::*;

  localparam int MagWidth = VALUE_WIDTH + 8;
  localparam logic [MagWidth-1:0] HalfMag = MagWidth'(1) << (VALUE_WIDTH - 1);

  logic                   take;
  logic                   fin_move;
  logic [VALUE_WIDTH-1:0] done_whole;
  fin_t                   done_info;

  // Finish stage: one number whose last character has been taken.
  logic                   fin_valid;
  logic [VALUE_WIDTH-1:0] fin_whole;
  fin_t                   fin_info;

  logic [MagWidth-1:0]    mag;
  logic [MagWidth-1:0]    limit;
  logic                   too_big;
  status_t                status_next;
  logic [VALUE_WIDTH-1:0] value_next;

  // Advance the finish stage whenever the result register is empty or draining.
  assign fin_move = fin_valid && (!out_valid || out_ready);
  assign in_ready = !fin_valid || fin_move;
  assign take     = in_valid && in_ready;

  dtfp_parse #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .char_code  (char_code),
    .is_last    (is_last),
    .done_whole (done_whole),
    .done_info  (done_info)
  );

  // Magnitude = whole * 100 + scaled fraction, then check the signed range.
  always_comb begin
    mag = {2'b00, fin_whole, 6'b0} + {3'b000, fin_whole, 5'b0}
          + {6'b0, fin_whole, 2'b00}
          + MagWidth'(frac_scaled(fin_info.frac_accum, fin_info.frac_count));
    limit       = fin_info.neg ? HalfMag : HalfMag - MagWidth'(1);
    too_big     = mag > limit;
    status_next = fin_info.status;
    value_next  = '0;
    if (fin_info.status == ST_OK) begin
      if (too_big) begin
        status_next = ST_OVERFLOW;
      end else if (fin_info.neg) begin
        value_next = VALUE_WIDTH'(-mag);
      end else begin
        value_next = mag[VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && is_last) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new record moves in.
  always_ff @(posedge clk) begin
    if (take && is_last) begin
      fin_whole <= done_whole;
      fin_info  <= done_info;
    end
    if (fin_move) begin
      hundredths <= value_next;
      status     <= status_next;
    end
  end

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> hundredths == '0)
    else $error("nonzero value with error status");

  a_last_fills_finish: assert property (@(posedge clk) disable iff (rst)
    take && is_last |=> fin_valid)
    else $error("final character did not reach the finish stage");

  a_finish_to_result: assert property (@(posedge clk) disable iff (rst)
    fin_move |=> out_valid)
    else $error("finished number did not reach the result register");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_move |=> fin_valid && $stable(fin_whole))
    else $error("finish stage lost a pending number");

endmodule

FILE: rtl/dtfp_parse.sv
`timescale 1ns / 1ps
// Per-character parser: phase, sign, accumulators and sticky first error.
module dtfp_parse #(
  parameter int VALUE_WIDTH = dtfp_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             char_code,
  input  logic                   is_last,
  output logic [VALUE_WIDTH-1:0] done_whole,
  output dtfp_pkg::fin_t         done_info
);
  import dtfp_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_INT, PH_FRAC} phase_t;

  localparam logic [VALUE_WIDTH:0] HalfRange = (VALUE_WIDTH+1)'(1) << (VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH:0] WholeCeil = HalfRange / (VALUE_WIDTH+1)'(100)
                                               + (VALUE_WIDTH+1)'(1);
  localparam logic [VALUE_WIDTH+3:0] CeilWide = (VALUE_WIDTH+4)'(WholeCeil);

  phase_t                 phase, phase_next;
  logic                   neg, neg_next;
  logic [VALUE_WIDTH-1:0] whole, whole_next;
  logic [6:0]             facc, facc_next;
  logic [1:0]             fcnt, fcnt_next;
  logic                   seen, seen_next;
  status_t                err, err_next;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [VALUE_WIDTH+3:0] whole_grow;

  always_comb begin
    is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    digit      = char_code[3:0];
    whole_grow = {3'b000, whole, 1'b0} + {1'b0, whole, 3'b000}
                 + (VALUE_WIDTH+4)'(digit);

    phase_next = phase;
    neg_next   = neg;
    whole_next = whole;
    facc_next  = facc;
    fcnt_next  = fcnt;
    seen_next  = seen;
    err_next   = err;

    if (err == ST_OK) begin
      case (phase)
        PH_START, PH_INT: begin
          phase_next = PH_INT;
          if (phase == PH_START && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
            neg_next = (char_code == CH_MINUS);
            if (is_last) begin
              err_next = ST_EMPTY;
            end
          end else if (char_code == CH_POINT) begin
            phase_next = PH_FRAC;
          end else if (!is_digit) begin
            err_next = ST_BAD_INT;
          end else begin
            // Saturate at a ceiling that is already out of range.
            whole_next = (whole_grow > CeilWide) ? WholeCeil[VALUE_WIDTH-1:0]
                                                 : whole_grow[VALUE_WIDTH-1:0];
            seen_next  = 1'b1;
          end
        end
        PH_FRAC: begin
          if (!is_digit) begin
            err_next = ST_BAD_FRAC;
          end else if (fcnt == 2'd2 || fcnt == 2'd3) begin
            err_next = ST_TOO_MANY;
          end else begin
            facc_next = 7'({facc, 3'b000} + {2'b00, facc, 1'b0} + {3'b000, digit});
            fcnt_next = fcnt + 2'd1;
            seen_next = 1'b1;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    done_whole            = whole_next;
    done_info.neg         = neg_next;
    done_info.frac_accum  = facc_next;
    done_info.frac_count  = fcnt_next;
    done_info.status      = (err_next == ST_OK && !seen_next) ? ST_NO_DIGITS : err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      neg   <= 1'b0;
      whole <= '0;
      facc  <= '0;
      fcnt  <= '0;
      seen  <= 1'b0;
      err   <= ST_OK;
    end else if (take) begin
      if (is_last) begin
        // Start over for the next number.
        phase <= PH_START;
        neg   <= 1'b0;
        whole <= '0;
        facc  <= '0;
        fcnt  <= '0;
        seen  <= 1'b0;
        err   <= ST_OK;
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
        whole <= whole_next;
        facc  <= facc_next;
        fcnt  <= fcnt_next;
        seen  <= seen_next;
        err   <= err_next;
      end
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming decimal text to hundredths parser.
module testbench;
  import dtfp_pkg::*;

  localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;

  // Range edge of the signed result, in hundredths, and the integer-part ceiling.
  localparam logic [63:0] HALF_RANGE = 64'd1 << (VALUE_WIDTH - 1);
  localparam logic [63:0] WHOLE_CAP  = HALF_RANGE / 100 + 1;

  localparam int PHASE_ITEMS  = 360;     // random characters per idling phase
  localparam int HOLD_LEN     = 400;     // long receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 10;      // margin after the last result is checked
  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic [1:0] {PH_START, PH_WHOLE, PH_FRAC} parse_phase_e;

  typedef enum int {M_FREE, M_SEND_IDLE, M_RECV_STALL, M_BOTH, M_PRESSURE} flow_mode_e;

  // Running parse of one number, mirrored from the block's behavior.
  typedef struct packed {
    parse_phase_e phase;
    logic         neg;
    logic [63:0]  whole;
    logic [6:0]   frac_acc;
    logic [1:0]   frac_cnt;
    logic         seen;
    status_t      err;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    status_t                       code;
  } fixed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [7:0]                    char_code = 8'd0;
  logic                          is_last   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] hundredths;
  status_t                       status;

  text_char_t    char_queue[$];      // characters not yet offered to the block
  fixed_result_t expected_values[$]; // predicted results in arrival order
  logic [7:0]    draft[$];           // scratch text of the number being built
  parse_state_t  ps;

  flow_mode_e mode         = M_FREE;
  int         queued_total = 0;
  int         fail_count   = 0;
  int         hold_count   = 0;
  int         cycle_count  = 0;

  string directed_texts [23] = '{
    "0", "-0", "+5", "123.45", "9.5", ".5", "5.", "-", "+", ".", "-.",
    "1a", "1.x", "1.23x", "1.234", "--1", "a123", "+007.00",
    "92233720368547758.07", "92233720368547758.08",
    "-92233720368547758.08", "-92233720368547758.09",
    "99999999999999999999x"
  };

  decimal_text_to_fixed_point #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hundredths(hundredths),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic parse_state_t fresh_parse();
    parse_state_t s;
    begin
      s.phase    = PH_START;
      s.neg      = 1'b0;
      s.whole    = '0;
      s.frac_acc = '0;
      s.frac_cnt = '0;
      s.seen     = 1'b0;
      s.err      = ST_OK;
      return s;
    end
  endfunction

  // Advance the parse by one accepted character; on the last character,
  // queue the predicted result and start over.
  task automatic take_char(input logic [7:0] c, input logic last);
    logic          consumed;
    logic          is_dig;
    logic [63:0]   next_whole;
    logic [63:0]   frac;
    logic [63:0]   mag;
    logic [63:0]   limit;
    fixed_result_t res;
    begin
      consumed = 1'b0;
      is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
      // Sticky error: ignore the rest of the number once an error is set.
      if (ps.err == ST_OK) begin
        if (ps.phase == PH_START) begin
          ps.phase = PH_WHOLE;
          if (c == CH_PLUS || c == CH_MINUS) begin
            ps.neg = (c == CH_MINUS);
            if (last) ps.err = ST_EMPTY;
            consumed = 1'b1;
          end
        end
        if (!consumed) begin
          if (ps.phase == PH_WHOLE) begin
            if (c == CH_POINT) begin
              ps.phase = PH_FRAC;
            end else if (!is_dig) begin
              ps.err = ST_BAD_INT;
            end else begin
              // Saturate at a ceiling that is already out of range.
              next_whole = ps.whole * 10 + 64'(c - CH_ZERO);
              ps.whole   = (next_whole > WHOLE_CAP) ? WHOLE_CAP : next_whole;
              ps.seen    = 1'b1;
            end
          end else begin
            if (!is_dig) begin
              ps.err = ST_BAD_FRAC;
            end else if (ps.frac_cnt >= 2) begin
              ps.err = ST_TOO_MANY;
            end else begin
              ps.frac_acc = 7'(ps.frac_acc * 10 + (c - CH_ZERO));
              ps.frac_cnt = ps.frac_cnt + 2'd1;
              ps.seen     = 1'b1;
            end
          end
        end
      end

      if (last) begin
        res.code  = ps.err;
        res.value = '0;
        if (res.code == ST_OK && !ps.seen) res.code = ST_NO_DIGITS;
        if (res.code == ST_OK) begin
          case (ps.frac_cnt)
            2'd0:    frac = 64'd0;
            2'd1:    frac = 64'(ps.frac_acc) * 10;
            default: frac = 64'(ps.frac_acc);
          endcase
          mag   = ps.whole * 100 + frac;
          limit = ps.neg ? HALF_RANGE : HALF_RANGE - 64'd1;
          if (mag > limit) begin
            res.code = ST_OVERFLOW;
          end else begin
            res.value = VALUE_WIDTH'(ps.neg ? (64'd0 - mag) : mag);
          end
        end
        expected_values = {expected_values, res};
        ps = fresh_parse();
      end
    end
  endtask

  task automatic push_item(input logic [7:0] c, input logic last);
    text_char_t item;
    begin
      item.code = c;
      item.last = last;
      char_queue = {char_queue, item};
      queued_total++;
    end
  endtask

  task automatic push_text(input string txt);
    begin
      for (int i = 0; i < txt.len(); i++) push_item(txt[i], i == txt.len() - 1);
    end
  endtask

  // Build one number: mostly well-formed with random content, some hugging
  // the signed limit, some far too long, some corrupted, some pure noise.
  task automatic queue_random_number();
    string edge_digits;
    int    pick;
    int    n_whole;
    int    n_frac;
    int    pos;
    begin
      edge_digits = "92233720368547758";
      draft.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
        n_whole = $urandom_range(1, 6);
        repeat (n_whole) draft = {draft, 8'($urandom)};
      end else begin
        case ($urandom_range(2))
          1:       draft = {draft, CH_PLUS};
          2:       draft = {draft, CH_MINUS};
          default: ;
        endcase
        if (pick < 14) begin
          for (int i = 0; i < edge_digits.len(); i++) draft = {draft, 8'(edge_digits[i])};
          if ($urandom_range(99) < 20) draft = {draft, 8'(CH_ZERO + $urandom_range(9))};
          draft = {draft, CH_POINT};
          draft = {draft, CH_ZERO};
          draft = {draft, 8'(CH_ZERO + $urandom_range(5, 9))};
        end else begin
          pick = $urandom_range(99);
          if (pick < 10)      n_whole = 0;
          else if (pick < 75) n_whole = $urandom_range(1, 4);
          else if (pick < 90) n_whole = $urandom_range(5, 12);
          else                n_whole = $urandom_range(18, 22);
          repeat (n_whole) draft = {draft, 8'(CH_ZERO + $urandom_range(9))};
          if ($urandom_range(99) < 65) begin
            draft = {draft, CH_POINT};
            pick = $urandom_range(99);
            if (pick < 10)      n_frac = 0;
            else if (pick < 40) n_frac = 1;
            else if (pick < 85) n_frac = 2;
            else                n_frac = 3;
            repeat (n_frac) draft = {draft, 8'(CH_ZERO + $urandom_range(9))};
          end
        end
        // Break the sequence now and then with one random byte.
        if (draft.size() > 0 && $urandom_range(99) < 12) begin
          pos        = $urandom_range(draft.size() - 1);
          draft[pos] = 8'($urandom);
        end
      end
      // An empty number cannot be sent.
      if (draft.size() == 0) draft = {draft, 8'(CH_ZERO + $urandom_range(9))};
      for (int i = 0; i < draft.size(); i++) push_item(draft[i], i == draft.size() - 1);
    end
  endtask

  task automatic fill_to(input int target);
    begin
      while (queued_total < target) queue_random_number();
    end
  endtask

  // Driver: predict on each input transfer, then offer the next character
  // unless the current idling phase says to hold back.
  always @(posedge clk) begin : drive_chars
    text_char_t item;
    logic       idle;
    if (rst) begin
      in_valid  <= 1'b0;
      char_code <= 8'd0;
      is_last   <= 1'b0;
      ps = fresh_parse();
    end else begin
      if (in_valid && in_ready) take_char(char_code, is_last);
      if (!in_valid || in_ready) begin
        idle = (mode == M_SEND_IDLE && $urandom_range(99) < 87) ||
               (mode == M_BOTH && $urandom_range(99) < 11);
        if (char_queue.size() > 0 && !idle) begin
          item = char_queue.pop_front();
          in_valid  <= 1'b1;
          char_code <= item.code;
          is_last   <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction,
  // then pick the next ready level for this idling phase.
  always @(posedge clk) begin : watch_results
    fixed_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $error("result with no prediction: hundredths %0d status %0d", hundredths, status);
          fail_count++;
        end else begin
          want = expected_values.pop_front();
          if (hundredths !== want.value) begin
            $error("hundredths: expected %0d, actual %0d", want.value, hundredths);
            fail_count++;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, actual %0d", want.code, status);
            fail_count++;
          end
        end
      end
      case (mode)
        M_RECV_STALL: out_ready <= ($urandom_range(99) >= 87);
        M_BOTH:       out_ready <= ($urandom_range(99) >= 11);
        M_PRESSURE: begin
          // Hold off long enough for the block to fill and stall its input.
          if (hold_count < HOLD_LEN) begin
            hold_count++;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texts: extremes, every status, sign and point corners.
    mode = M_FREE;
    foreach (directed_texts[i]) push_text(directed_texts[i]);
    push_text("99999999999999999999999");
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b1);

    // Random numbers, one idling phase after another.
    for (int m = M_FREE; m <= M_PRESSURE; m++) begin
      while (char_queue.size() != 0) @(negedge clk);
      mode = flow_mode_e'(m);
      fill_to(queued_total + PHASE_ITEMS);
    end

    // Drain: every character taken, every prediction met, then a margin.
    while (char_queue.size() != 0 || in_valid || expected_values.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
